// File: hdl/fat12te_pkg.sv
// Shared types, constants and address helpers for the FAT12 table engine.
`timescale 1ns / 1ps
`default_nettype none

package fat12te_pkg;

  // Fixed field widths of the channels.
  localparam int ACTION_W  = 2;
  localparam int BADDR_W   = 13;
  localparam int ENTRY_W   = 12;
  localparam int TS_W      = 13;
  localparam int FREE_W    = 22;
  localparam int ROW_MAX_W = 12;

  // Defaults for the top-level parameters.
  localparam int MAX_ENTRIES_DEF       = 4096;
  localparam int BYTES_PER_CLUSTER_DEF = 512;

  // Reset value of the sector count register and the free-space ceiling.
  localparam logic [TS_W-1:0]   TS_RESET = 13'd2880;
  localparam logic [FREE_W-1:0] FREE_MAX = 22'h3FFFFF;

  // Depth of the command queue between front and back.
  localparam int QDEPTH = 2;

  // Action codes carried on the input channel.
  typedef enum logic [ACTION_W-1:0] {
    ACT_LOAD  = 2'd0,
    ACT_READ  = 2'd1,
    ACT_WRITE = 2'd2,
    ACT_COUNT = 2'd3
  } action_t;

  // Commands handed from the front to the back.
  typedef enum logic [2:0] {
    CMD_LOAD,
    CMD_READ,
    CMD_READ_NULL,
    CMD_WRITE,
    CMD_COUNT
  } cmd_kind_t;

  // Where the two bytes of an entry sit in the even and odd byte banks.
  typedef struct packed {
    logic                 swap;   // low byte of the entry is in the odd bank
    logic                 odd;    // odd entry: uses the upper nibble layout
    logic [ROW_MAX_W-1:0] row_e;
    logic [ROW_MAX_W-1:0] row_o;
  } loc_t;

  typedef struct packed {
    cmd_kind_t          kind;
    loc_t               loc;
    logic [ENTRY_W-1:0] data;
  } cmd_t;

  // Push side of the queue.
  typedef struct packed {
    logic push;
    cmd_t cmd;
  } q_push_t;

  // Head of the queue as the back sees it.
  typedef struct packed {
    logic vld;
    cmd_t cmd;
  } q_head_t;

  // Back-end sequencer states.
  typedef enum logic [2:0] {
    B_IDLE,
    B_ACC,
    B_SCAN,
    B_DRAIN,
    B_MUL,
    B_FREE
  } bst_t;

  // Entry n starts at byte floor(3n/2); bytes alternate between the banks.
  function automatic loc_t entry_loc(input logic [ENTRY_W-1:0] n);
    logic [BADDR_W:0]     b3;
    logic [ROW_MAX_W-1:0] r;
    loc_t                 l;
    b3      = {2'b00, n} + {1'b0, n, 1'b0};
    r       = b3[ROW_MAX_W+1:2];
    l.odd   = n[0];
    l.swap  = b3[1];
    l.row_o = r;
    l.row_e = b3[1] ? r + ROW_MAX_W'(1) : r;
    return l;
  endfunction

endpackage

`default_nettype wire

// File: hdl/fat12te_if.sv
// Channel interfaces of the FAT12 table engine: input, result and configuration.
`timescale 1ns / 1ps
`default_nettype none

interface fat12te_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [12:0] byte_address;
  logic [7:0]  load_byte;
  logic [11:0] entry_index;
  logic [11:0] entry_data;

  modport source (output valid, action, byte_address, load_byte, entry_index, entry_data,
                  input ready);
  modport sink   (input valid, action, byte_address, load_byte, entry_index, entry_data,
                  output ready);
endinterface

interface fat12te_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [11:0] entry_value;
  logic [21:0] free_bytes;

  modport source (output valid, result_kind, entry_value, free_bytes, input ready);
  modport sink   (input valid, result_kind, entry_value, free_bytes, output ready);
endinterface

interface fat12te_cfg_if;
  logic        valid;
  logic        ready;
  logic [12:0] total_sectors;

  modport source (output valid, total_sectors, input ready);
  modport sink   (input valid, total_sectors, output ready);
endinterface

`default_nettype wire

// File: hdl/fat12te_front.sv
// Front end: takes input words, range-checks them and turns them into commands.
`timescale 1ns / 1ps
`default_nettype none

module fat12te_front
  import fat12te_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  wire           clk,
  input  wire           rst_n,
  fat12te_in_if.sink    in_ch,
  input  wire           q_full,
  output q_push_t       q_push
);

  localparam int STORE_BYTES = (MAX_ENTRIES * 3) / 2;

  logic    f_vld_r, f_vld_nxt;
  cmd_t    f_cmd_r, f_cmd_nxt;
  logic    accept;
  logic    keep;
  logic    idx_ok;
  action_t act;

  // A held command leaves as soon as the queue has room.
  assign in_ch.ready = !f_vld_r || !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign act         = action_t'(in_ch.action);
  assign idx_ok      = {1'b0, in_ch.entry_index} < 13'(MAX_ENTRIES);

  // Classify the word; loads and writes that fall outside the table are dropped.
  always_comb begin
    keep               = 1'b0;
    f_cmd_nxt          = f_cmd_r;
    unique case (act)
      ACT_LOAD: begin
        keep               = in_ch.byte_address < 13'(STORE_BYTES);
        f_cmd_nxt.kind     = CMD_LOAD;
        f_cmd_nxt.loc.swap = in_ch.byte_address[0];
        f_cmd_nxt.loc.odd  = 1'b0;
        f_cmd_nxt.loc.row_e = in_ch.byte_address[BADDR_W-1:1];
        f_cmd_nxt.loc.row_o = in_ch.byte_address[BADDR_W-1:1];
        f_cmd_nxt.data     = {4'h0, in_ch.load_byte};
      end
      ACT_READ: begin
        keep           = 1'b1;
        f_cmd_nxt.kind = idx_ok ? CMD_READ : CMD_READ_NULL;
        f_cmd_nxt.loc  = entry_loc(in_ch.entry_index);
        f_cmd_nxt.data = in_ch.entry_data;
      end
      ACT_WRITE: begin
        keep           = idx_ok;
        f_cmd_nxt.kind = CMD_WRITE;
        f_cmd_nxt.loc  = entry_loc(in_ch.entry_index);
        f_cmd_nxt.data = in_ch.entry_data;
      end
      ACT_COUNT: begin
        keep           = 1'b1;
        f_cmd_nxt.kind = CMD_COUNT;
        f_cmd_nxt.loc  = entry_loc(in_ch.entry_index);
        f_cmd_nxt.data = in_ch.entry_data;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
    if (!accept) begin
      f_cmd_nxt = f_cmd_r;
    end
  end

  // Valid of the holding register.
  always_comb begin
    if (accept) begin
      f_vld_nxt = keep;
    end else if (f_vld_r && !q_full) begin
      f_vld_nxt = 1'b0;
    end else begin
      f_vld_nxt = f_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else begin
      f_vld_r <= f_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    f_cmd_r <= f_cmd_nxt;
  end

  assign q_push.push = f_vld_r && !q_full;
  assign q_push.cmd  = f_cmd_r;

endmodule

`default_nettype wire

// File: hdl/fat12te_queue.sv
// Short command queue that decouples the front end from the back end.
`timescale 1ns / 1ps
`default_nettype none

module fat12te_queue
  import fat12te_pkg::*;
(
  input  wire     clk,
  input  wire     rst_n,
  input  q_push_t q_push,
  output logic    q_full,
  input  wire     pop,
  output q_head_t q_head
);

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  cmd_t             slot_r [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign q_full      = cnt_r == CNT_W'(QDEPTH);
  assign q_head.vld  = cnt_r != '0;
  assign q_head.cmd  = slot_r[rd_ptr_r];
  assign do_push     = q_push.push && !q_full;
  assign do_pop      = pop && q_head.vld;

  // Pointer and fill count update with wraparound at the queue depth.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= q_push.cmd;
    end
  end

endmodule

`default_nettype wire

// File: hdl/fat12te_back.sv
// Back end: banked table memory, command sequencer, free-entry scan and result register.
`timescale 1ns / 1ps
`default_nettype none

module fat12te_back
  import fat12te_pkg::*;
#(
  parameter int MAX_ENTRIES       = MAX_ENTRIES_DEF,
  parameter int BYTES_PER_CLUSTER = BYTES_PER_CLUSTER_DEF
) (
  input  wire             clk,
  input  wire             rst_n,
  input  q_head_t         q_head,
  output logic            pop,
  input  wire [TS_W-1:0]  total_sectors,
  fat12te_out_if.source   out_ch
);

  localparam int STORE_BYTES = (MAX_ENTRIES * 3) / 2;
  localparam int ROWS        = (STORE_BYTES + 1) / 2;
  localparam int ROW_W       = $clog2(ROWS);
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int BPC_W       = $clog2(BYTES_PER_CLUSTER + 1);
  localparam int PROD_W      = IDX_W + BPC_W;
  localparam int SAT_W       = (PROD_W > FREE_W) ? PROD_W : FREE_W;

  // Even-address and odd-address byte banks.
  logic [7:0] bank_e [ROWS];
  logic [7:0] bank_o [ROWS];

  bst_t              state_r, state_nxt;
  cmd_t              cur_r, cur_nxt;
  logic [IDX_W-1:0]  scan_n_r, scan_n_nxt;
  logic [IDX_W-1:0]  last_n_r, last_n_nxt;
  logic              chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0]  tally_r, tally_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic              out_vld_r, out_vld_nxt;
  logic              out_kind_r, out_kind_nxt;
  logic [11:0]       out_val_r, out_val_nxt;
  logic [FREE_W-1:0] out_free_r, out_free_nxt;

  logic              re;
  loc_t              rloc;
  logic [7:0]        rd_e_r, rd_o_r;
  logic              rd_odd_r, rd_swap_r;
  logic              we_e, we_o;
  logic [ROW_W-1:0]  wrow_e, wrow_o;
  logic [7:0]        wdat_e, wdat_o;

  logic              slot_free;
  logic [7:0]        lo, hi, new_lo, new_hi;
  logic [11:0]       ent_val;
  logic [TS_W-1:0]   bound;
  logic [SAT_W-1:0]  prod_wide;
  loc_t              scan_loc;

  assign slot_free = !out_vld_r || out_ch.ready;

  // Unpack the entry from the two registered bank bytes.
  assign lo      = rd_swap_r ? rd_o_r : rd_e_r;
  assign hi      = rd_swap_r ? rd_e_r : rd_o_r;
  assign ent_val = rd_odd_r ? {hi, lo[7:4]} : {hi[3:0], lo};

  // Merge a new value into the old bytes, keeping the neighbor's nibble.
  always_comb begin
    if (cur_r.loc.odd) begin
      new_lo = {cur_r.data[3:0], lo[3:0]};
      new_hi = cur_r.data[11:4];
    end else begin
      new_lo = cur_r.data[7:0];
      new_hi = {hi[7:4], cur_r.data[11:8]};
    end
  end

  assign bound     = (total_sectors > TS_W'(MAX_ENTRIES)) ? TS_W'(MAX_ENTRIES) : total_sectors;
  assign scan_loc  = entry_loc(ENTRY_W'(scan_n_r));
  assign prod_wide = SAT_W'(prod_r);

  // Sequencer: next state, memory controls and result register loading.
  always_comb begin
    state_nxt    = state_r;
    cur_nxt      = cur_r;
    scan_n_nxt   = scan_n_r;
    last_n_nxt   = last_n_r;
    chk_vld_nxt  = 1'b0;
    prod_nxt     = prod_r;
    out_vld_nxt  = out_vld_r && !out_ch.ready;
    out_kind_nxt = out_kind_r;
    out_val_nxt  = out_val_r;
    out_free_nxt = out_free_r;
    pop          = 1'b0;
    re           = 1'b0;
    rloc         = q_head.cmd.loc;
    we_e         = 1'b0;
    we_o         = 1'b0;
    wrow_e       = cur_r.loc.row_e[ROW_W-1:0];
    wrow_o       = cur_r.loc.row_o[ROW_W-1:0];
    wdat_e       = cur_r.loc.swap ? new_hi : new_lo;
    wdat_o       = cur_r.loc.swap ? new_lo : new_hi;

    // Each zero entry seen by the scan bumps the tally.
    tally_nxt = tally_r;
    if (chk_vld_r && ent_val == 12'h000) begin
      tally_nxt = tally_r + IDX_W'(1);
    end

    unique case (state_r)
      B_IDLE: begin
        if (q_head.vld) begin
          unique case (q_head.cmd.kind)
            CMD_LOAD: begin
              pop    = 1'b1;
              wrow_e = q_head.cmd.loc.row_e[ROW_W-1:0];
              wrow_o = q_head.cmd.loc.row_e[ROW_W-1:0];
              wdat_e = q_head.cmd.data[7:0];
              wdat_o = q_head.cmd.data[7:0];
              we_e   = !q_head.cmd.loc.swap;
              we_o   = q_head.cmd.loc.swap;
            end
            CMD_READ_NULL: begin
              if (slot_free) begin
                pop          = 1'b1;
                out_vld_nxt  = 1'b1;
                out_kind_nxt = 1'b0;
                out_val_nxt  = '0;
                out_free_nxt = '0;
              end
            end
            CMD_READ, CMD_WRITE: begin
              pop       = 1'b1;
              re        = 1'b1;
              cur_nxt   = q_head.cmd;
              state_nxt = B_ACC;
            end
            CMD_COUNT: begin
              pop       = 1'b1;
              tally_nxt = '0;
              if (bound <= TS_W'(2)) begin
                state_nxt = B_MUL;
              end else begin
                scan_n_nxt = IDX_W'(2);
                last_n_nxt = IDX_W'(bound - TS_W'(1));
                state_nxt  = B_SCAN;
              end
            end
            default: begin
              pop = 1'b1;
            end
          endcase
        end
      end
      B_ACC: begin
        if (cur_r.kind == CMD_WRITE) begin
          we_e      = 1'b1;
          we_o      = 1'b1;
          state_nxt = B_IDLE;
        end else if (slot_free) begin
          out_vld_nxt  = 1'b1;
          out_kind_nxt = 1'b0;
          out_val_nxt  = ent_val;
          out_free_nxt = '0;
          state_nxt    = B_IDLE;
        end
      end
      B_SCAN: begin
        re          = 1'b1;
        rloc        = scan_loc;
        chk_vld_nxt = 1'b1;
        if (scan_n_r == last_n_r) begin
          state_nxt = B_DRAIN;
        end else begin
          scan_n_nxt = scan_n_r + IDX_W'(1);
        end
      end
      B_DRAIN: begin
        state_nxt = B_MUL;
      end
      B_MUL: begin
        prod_nxt  = PROD_W'(tally_r) * PROD_W'(BYTES_PER_CLUSTER);
        state_nxt = B_FREE;
      end
      B_FREE: begin
        if (slot_free) begin
          out_vld_nxt  = 1'b1;
          out_kind_nxt = 1'b1;
          out_val_nxt  = '0;
          out_free_nxt = (prod_wide > SAT_W'(FREE_MAX)) ? FREE_MAX : prod_wide[FREE_W-1:0];
          state_nxt    = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= B_IDLE;
      scan_n_r  <= '0;
      last_n_r  <= '0;
      chk_vld_r <= 1'b0;
      tally_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      scan_n_r  <= scan_n_nxt;
      last_n_r  <= last_n_nxt;
      chk_vld_r <= chk_vld_nxt;
      tally_r   <= tally_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    prod_r     <= prod_nxt;
    out_kind_r <= out_kind_nxt;
    out_val_r  <= out_val_nxt;
    out_free_r <= out_free_nxt;
  end

  // Even bank: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we_e) begin
      bank_e[wrow_e] <= wdat_e;
    end
    if (re) begin
      rd_e_r <= bank_e[rloc.row_e[ROW_W-1:0]];
    end
  end

  // Odd bank, plus the layout bits that travel with the read data.
  always_ff @(posedge clk) begin
    if (we_o) begin
      bank_o[wrow_o] <= wdat_o;
    end
    if (re) begin
      rd_o_r    <= bank_o[rloc.row_o[ROW_W-1:0]];
      rd_odd_r  <= rloc.odd;
      rd_swap_r <= rloc.swap;
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.result_kind = out_kind_r;
  assign out_ch.entry_value = out_val_r;
  assign out_ch.free_bytes  = out_free_r;

  // A tally check only follows a scan read.
  a_chk_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    chk_vld_r |-> $past(state_r == B_SCAN))
    else $error("scan check without a preceding scan read");

  // The scan index never runs past its bound.
  a_scan_in_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_SCAN) |-> (scan_n_r <= last_n_r))
    else $error("scan index beyond bound");

  // The back only takes a command that is present.
  a_pop_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_head.vld)
    else $error("pop from an empty queue");

  // A result is never loaded over one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_ch.ready) |=> (out_vld_r && $stable(out_free_r) && $stable(out_val_r)))
    else $error("pending result overwritten");

endmodule

`default_nettype wire

// File: hdl/fat12_table_engine_unit.sv
// Top level of the FAT12 table engine: channels, sector count register and the three parts.
`timescale 1ns / 1ps
`default_nettype none

// The engine keeps a packed FAT12 table (two 12-bit entries in every three
// bytes) in two byte banks, even and odd addresses, so both bytes of an entry
// are read or written in the same cycle. A load word stores one byte, a read
// does a bank read and then unpacks into the result register, and a write
// does a bank read and then a nibble merge and write back. A count takes the
// command, walks any entries 2 through min(total_sectors, MAX_ENTRIES)-1 at one
// entry per cycle through the bank read port and then passes B_DRAIN (the last
// tally update), B_MUL (the multiply by BYTES_PER_CLUSTER) and B_FREE (the
// result). Commands pass through the front register and the command queue on
// their way to the back. Once the back stalls on a result that cannot be
// stored, up to three more input words are taken (one in the front register
// and two in the queue) before the input stalls.
// Table bytes have no reset; reading a byte that was never loaded returns
// whatever the memory holds. total_sectors resets to 2880 and may be written
// only while the engine is idle.
module fat12_table_engine_unit
  import fat12te_pkg::*;
#(
  parameter int MAX_ENTRIES       = MAX_ENTRIES_DEF,
  parameter int BYTES_PER_CLUSTER = BYTES_PER_CLUSTER_DEF
) (
  input  wire            clk,
  input  wire            rst_n,
  fat12te_in_if.sink     in_ch,
  fat12te_out_if.source  out_ch,
  fat12te_cfg_if.sink    cfg_ch
);

  logic [TS_W-1:0] total_sectors_r, total_sectors_nxt;
  q_push_t         q_push;
  q_head_t         q_head;
  logic            q_full;
  logic            pop;

  // Sector count register; writes are always taken.
  assign cfg_ch.ready      = 1'b1;
  assign total_sectors_nxt = (cfg_ch.valid && cfg_ch.ready) ? cfg_ch.total_sectors
                                                              : total_sectors_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_sectors_r <= TS_RESET;
    end else begin
      total_sectors_r <= total_sectors_nxt;
    end
  end

  fat12te_front #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push)
  );

  fat12te_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .q_full (q_full),
    .pop    (pop),
    .q_head (q_head)
  );

  fat12te_back #(
    .MAX_ENTRIES       (MAX_ENTRIES),
    .BYTES_PER_CLUSTER (BYTES_PER_CLUSTER)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_head        (q_head),
    .pop           (pop),
    .total_sectors (total_sectors_r),
    .out_ch        (out_ch)
  );

endmodule

`default_nettype wire

// File: verif/tb.sv
// Self-checking testbench for the FAT12 table engine with a scoreboard and random traffic.
`timescale 1ns / 1ps

module tb;
  import fat12te_pkg::*;

  localparam int          STORE_BYTES = (MAX_ENTRIES_DEF * 3) / 2;
  localparam int unsigned CYCLE_LIMIT = 4000000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int          PHASES      = 14;
  localparam int          PHASE_WORDS = 72;

  // One input word as the sender offers it.
  typedef struct packed {
    action_t     action;
    logic [12:0] byte_address;
    logic [7:0]  load_byte;
    logic [11:0] entry_index;
    logic [11:0] entry_data;
  } in_word_t;

  // One result word as the engine returns it.
  typedef struct packed {
    logic        kind;
    logic [11:0] value;
    logic [21:0] free;
  } fat_result_t;

  // Mirror of the packed table and the sector count, with the results still owed.
  class fat_table_mirror;
    logic [7:0]  table_bytes [STORE_BYTES];
    logic [12:0] sector_count;
    fat_result_t pending_results [$];
    int unsigned mismatches;

    function new();
      foreach (table_bytes[i]) table_bytes[i] = 8'h00;
      sector_count = TS_RESET;
      mismatches   = 0;
    endfunction

    // Entry n starts at byte 3n/2; odd entries use the upper nibble of that byte.
    function logic [11:0] entry_at(int unsigned n);
      int unsigned b;
      if (n >= MAX_ENTRIES_DEF) return 12'h000;
      b = (3 * n) / 2;
      if (n % 2 == 0) return {table_bytes[b+1][3:0], table_bytes[b]};
      return {table_bytes[b+1], table_bytes[b][7:4]};
    endfunction

    // A write keeps the nibble that belongs to the neighboring entry.
    function void put_entry(int unsigned n, logic [11:0] v);
      int unsigned b;
      if (n >= MAX_ENTRIES_DEF) return;
      b = (3 * n) / 2;
      if (n % 2 == 0) begin
        table_bytes[b+1] = {table_bytes[b+1][7:4], v[11:8]};
        table_bytes[b]   = v[7:0];
      end else begin
        table_bytes[b]   = {v[3:0], table_bytes[b][3:0]};
        table_bytes[b+1] = v[11:4];
      end
    endfunction

    function void set_sectors(logic [12:0] v);
      sector_count = v;
    endfunction

    // Apply one accepted word and queue the result it owes, if any.
    function void note_word(in_word_t w);
      fat_result_t r;
      int unsigned bound;
      int unsigned zeros;
      int unsigned space;
      r = '0;
      case (w.action)
        ACT_LOAD: begin
          if (w.byte_address < STORE_BYTES) table_bytes[w.byte_address] = w.load_byte;
        end
        ACT_WRITE: put_entry(w.entry_index, w.entry_data);
        ACT_READ: begin
          r.kind  = 1'b0;
          r.value = entry_at(w.entry_index);
          pending_results.push_back(r);
        end
        default: begin
          // The scan stops at the sector count, clamped to the table size.
          bound = (sector_count > MAX_ENTRIES_DEF) ? MAX_ENTRIES_DEF : sector_count;
          zeros = 0;
          for (int unsigned n = 2; n < bound; n++)
            if (entry_at(n) == 12'h000) zeros++;
          space = zeros * BYTES_PER_CLUSTER_DEF;
          if (space > 32'(FREE_MAX)) space = 32'(FREE_MAX);
          r.kind = 1'b1;
          r.free = space[21:0];
          pending_results.push_back(r);
        end
      endcase
    endfunction

    // Compare one accepted result word with the oldest one owed.
    function void check_result(logic kind, logic [11:0] value, logic [21:0] free);
      fat_result_t exp_r;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: kind %0d value %03h free %0d", kind, value, free);
        return;
      end
      exp_r = pending_results.pop_front();
      if (exp_r.kind !== kind || exp_r.value !== value || exp_r.free !== free) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: expected kind %0d value %03h free %0d, got kind %0d value %03h free %0d",
                   exp_r.kind, exp_r.value, exp_r.free, kind, value, free);
      end
    endfunction
  endclass

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  bit   hold_request = 1'b0;
  bit   no_idle      = 1'b0;
  int unsigned cycle_count = 0;

  fat_table_mirror mirror = new();

  fat12te_in_if  in_if ();
  fat12te_out_if out_if ();
  fat12te_cfg_if cfg_if ();

  fat12_table_engine_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Table bytes lean toward zero so that free counts stay interesting.
  function automatic logic [7:0] table_byte_value();
    if ($urandom_range(0, 1) == 0) return 8'h00;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic in_word_t make_word(action_t a, int unsigned addr, int unsigned value,
                                         int unsigned idx, int unsigned data);
    in_word_t w;
    w.action       = a;
    w.byte_address = 13'(addr);
    w.load_byte    = 8'(value);
    w.entry_index  = 12'(idx);
    w.entry_data   = 12'(data);
    return w;
  endfunction

  // Random word; a tenth of the loads aim past the end of the table.
  function automatic in_word_t random_word();
    in_word_t    w;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 9) == 0)
      w.byte_address = 13'($urandom_range(STORE_BYTES, 8191));
    else
      w.byte_address = 13'($urandom_range(0, STORE_BYTES - 1));
    w.load_byte   = table_byte_value();
    w.entry_index = 12'($urandom_range(0, 4095));
    w.entry_data  = ($urandom_range(0, 2) == 0) ? 12'h000 : 12'($urandom_range(0, 4095));
    if (pick < 25)      w.action = ACT_LOAD;
    else if (pick < 60) w.action = ACT_READ;
    else if (pick < 92) w.action = ACT_WRITE;
    else                w.action = ACT_COUNT;
    return w;
  endfunction

  // Offer one word until it is taken, then maybe leave a gap.
  task automatic send_word(input in_word_t w);
    int unsigned gap;
    in_if.valid        <= 1'b1;
    in_if.action       <= w.action;
    in_if.byte_address <= w.byte_address;
    in_if.load_byte    <= w.load_byte;
    in_if.entry_index  <= w.entry_index;
    in_if.entry_data   <= w.entry_data;
    do @(posedge clk); while (!in_if.ready);
    mirror.note_word(w);
    gap = no_idle ? 0 : pick_gap();
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering and wait for every owed result, then let loads and writes settle.
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (mirror.pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_sectors(input logic [12:0] v);
    cfg_if.valid         <= 1'b1;
    cfg_if.total_sectors <= v;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    mirror.set_sectors(v);
  endtask

  // Result side: ready with random gaps, one long hold-off on request.
  initial begin
    int unsigned run_len;
    int unsigned gap;
    out_if.ready <= 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else if (no_idle) begin
        out_if.ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_if.ready <= 1'b1;
        run_len = $urandom_range(1, 12);
        repeat (run_len) @(posedge clk);
        gap = pick_gap();
        if (gap != 0) begin
          out_if.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  // Check every result word taken by the receiver.
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      mirror.check_result(out_if.result_kind, out_if.entry_value, out_if.free_bytes);
  end

  // Stimulus: fill the table, directed words, then random phases per sector count.
  initial begin
    logic [12:0] phase_sectors [PHASES];
    phase_sectors = '{13'd2, 13'd0, 13'd17, 13'd1, 13'd4096, 13'd3, 13'd100, 13'd8191,
                      13'd40, 13'd2880, 13'd300, 13'd4097, 13'd64, 13'd5000};

    rst_n                <= 1'b0;
    in_if.valid          <= 1'b0;
    in_if.action         <= ACT_LOAD;
    in_if.byte_address   <= '0;
    in_if.load_byte      <= '0;
    in_if.entry_index    <= '0;
    in_if.entry_data     <= '0;
    cfg_if.valid         <= 1'b0;
    cfg_if.total_sectors <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Load every table byte so no read or scan ever touches an unwritten byte.
    for (int unsigned a = 0; a < STORE_BYTES; a++)
      send_word(make_word(ACT_LOAD, a, table_byte_value(), $urandom_range(0, 4095),
                          $urandom_range(0, 4095)));

    // Table ends, neighbor nibbles kept on writes, loads past the end ignored.
    send_word(make_word(ACT_READ,  0, 0, 0, 0));
    send_word(make_word(ACT_READ,  0, 0, 1, 0));
    send_word(make_word(ACT_READ,  0, 0, 4094, 0));
    send_word(make_word(ACT_READ,  0, 0, 4095, 0));
    send_word(make_word(ACT_WRITE, 0, 0, 0, 12'hFFF));
    send_word(make_word(ACT_READ,  0, 0, 0, 0));
    send_word(make_word(ACT_READ,  0, 0, 1, 0));
    send_word(make_word(ACT_WRITE, 0, 0, 1, 12'h000));
    send_word(make_word(ACT_READ,  0, 0, 0, 0));
    send_word(make_word(ACT_READ,  0, 0, 1, 0));
    send_word(make_word(ACT_WRITE, 0, 0, 4095, 12'hABC));
    send_word(make_word(ACT_READ,  0, 0, 4094, 0));
    send_word(make_word(ACT_READ,  0, 0, 4095, 0));
    send_word(make_word(ACT_WRITE, 0, 0, 2, 12'h000));
    send_word(make_word(ACT_WRITE, 0, 0, 3, 12'h5A5));
    send_word(make_word(ACT_LOAD,  0, 8'hFF, 0, 0));
    send_word(make_word(ACT_LOAD,  STORE_BYTES - 1, 8'h00, 0, 0));
    send_word(make_word(ACT_LOAD,  8191, 8'hAA, 0, 0));
    send_word(make_word(ACT_LOAD,  STORE_BYTES, 8'h55, 0, 0));
    send_word(make_word(ACT_READ,  0, 0, 0, 0));
    send_word(make_word(ACT_READ,  0, 0, 4095, 0));
    send_word(make_word(ACT_READ,  0, 0, 2, 0));
    // Count with the sector count still at its reset value.
    send_word(make_word(ACT_COUNT, 0, 0, 0, 0));

    // Random phases; one with a long receiver hold-off, one with no idling at all.
    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      write_sectors(phase_sectors[p]);
      if (p == 2) hold_request = 1'b1;
      no_idle = (p == 6);
      for (int i = 0; i < PHASE_WORDS; i++) send_word(random_word());
      no_idle = 1'b0;
    end

    wait_idle();
    if (mirror.mismatches == 0 && mirror.pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
